@@ src/sle_pkg.sv @@
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types, character codes and the overflow warning text for the
// serial line editor.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 6;
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = $clog2(MAX_RESULTS);
  localparam int WARN_LEN    = 17;

  // result kinds
  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_LINE = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;
  localparam logic [1:0] KIND_OVER = 2'd3;

  // character codes
  localparam logic [BYTE_W-1:0] CH_LF       = 8'd10;
  localparam logic [BYTE_W-1:0] CH_CR       = 8'd13;
  localparam logic [BYTE_W-1:0] CH_ESC      = 8'd27;
  localparam logic [BYTE_W-1:0] CH_LBRACKET = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_UPPER_A  = 8'h41;
  localparam logic [BYTE_W-1:0] CH_DEL      = 8'd127;

  // one result request
  typedef struct packed {
    logic [1:0]        kind;
    logic [BYTE_W-1:0] byte_value;
    logic [LEN_W-1:0]  line_length;
    logic              last;
  } result_t;

  // line store access from the sequencer
  typedef struct packed {
    logic              we;
    logic [LEN_W-1:0]  waddr;
    logic [BYTE_W-1:0] wdata;
    logic [LEN_W-1:0]  raddr;
  } mem_req_t;

  // "Buffer Exceeded\r\n"
  function automatic logic [BYTE_W-1:0] warn_char(input logic [4:0] i);
    logic [BYTE_W-1:0] c;
    case (i)
      5'd0:    c = 8'h42;
      5'd1:    c = 8'h75;
      5'd2:    c = 8'h66;
      5'd3:    c = 8'h66;
      5'd4:    c = 8'h65;
      5'd5:    c = 8'h72;
      5'd6:    c = 8'h20;
      5'd7:    c = 8'h45;
      5'd8:    c = 8'h78;
      5'd9:    c = 8'h63;
      5'd10:   c = 8'h65;
      5'd11:   c = 8'h65;
      5'd12:   c = 8'h64;
      5'd13:   c = 8'h65;
      5'd14:   c = 8'h64;
      5'd15:   c = CH_CR;
      5'd16:   c = CH_LF;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ src/sle_ram.sv @@
// ----------------------------------------------------------------------------
// sle_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/sle_out.sv @@
// ----------------------------------------------------------------------------
// sle_out
// Output register stage: holds one result request until the consumer takes it.
// ----------------------------------------------------------------------------
module sle_out import sle_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t res_in,
  output logic    space,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t res_out
);

  logic    valid;
  result_t data;

  // room when empty or when the held request leaves this cycle
  assign space     = !valid || !out_stall;
  assign out_valid = valid;
  assign res_out   = data;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (space) begin
      valid <= push;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (space && push) begin
      data <= res_in;
    end
  end

endmodule

@@ src/sle_ctrl.sv @@
// ----------------------------------------------------------------------------
// sle_ctrl
// Sequencer of the line editor: decodes each received byte, keeps the line
// state and steps a shared index counter over the line store or the warning
// text, one result request per cycle while the output register has room.
// ----------------------------------------------------------------------------
module sle_ctrl import sle_pkg::*; #(
  parameter int LINE_STORE = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [LEN_W-1:0]  limit,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic              space,
  output logic              push,
  output result_t           res,
  output mem_req_t          mem,
  input  logic [BYTE_W-1:0] rd_data
);

  localparam logic [LEN_W:0]   STORE_EXT = (LEN_W+1)'(LINE_STORE);
  localparam logic [LEN_W-1:0] STORE_M1  = LEN_W'(LINE_STORE - 1);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(MAX_RESULTS - 1);
  localparam logic [LEN_W-1:0] WARN_END  = LEN_W'(WARN_LEN - 1);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_ECHO   = 9'b000000010,
    S_CR     = 9'b000000100,
    S_LF     = 9'b000001000,
    S_LINE   = 9'b000010000,
    S_DONE   = 9'b000100000,
    S_RECALL = 9'b001000000,
    S_WARN   = 9'b010000000,
    S_OVER   = 9'b100000000
  } state_t;

  typedef enum logic [2:0] {
    ESC_NONE   = 3'b001,
    ESC_FIRST  = 3'b010,
    ESC_SECOND = 3'b100
  } esc_t;

  state_t            state, state_next;
  esc_t              escape_phase, escape_phase_next;
  logic [BYTE_W-1:0] escape_first, escape_first_next;
  logic [LEN_W-1:0]  position, position_next;
  logic [LEN_W-1:0]  recall_length, recall_length_next;
  logic [LEN_W-1:0]  idx, idx_next;
  logic [LEN_W-1:0]  end_cnt, end_cnt_next;
  logic [BYTE_W-1:0] echo_byte, echo_byte_next;
  logic              ovf_pend, ovf_pend_next;
  logic [CNT_W-1:0]  cnt, cnt_next;

  logic              accept;
  logic [LEN_W:0]    limit_ext;
  logic [LEN_W-1:0]  lim_m1;
  logic [LEN_W-1:0]  pos_inc;
  logic [LEN_W-1:0]  idx_inc;
  logic              at_end;
  logic              final_nat;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign pos_inc  = position + LEN_W'(1);
  assign idx_inc  = idx + LEN_W'(1);
  assign at_end   = (idx_inc == end_cnt);

  // overflow threshold: clamped limit minus one
  always_comb begin
    limit_ext = {1'b0, limit};
    if (limit_ext < (LEN_W+1)'(2)) begin
      lim_m1 = LEN_W'(1);
    end else if (limit_ext > STORE_EXT) begin
      lim_m1 = STORE_M1;
    end else begin
      lim_m1 = limit - LEN_W'(1);
    end
  end

  // result of the current state
  always_comb begin
    res.kind        = KIND_ECHO;
    res.byte_value  = '0;
    res.line_length = '0;
    final_nat       = 1'b0;
    case (state)
      S_ECHO: begin
        res.byte_value = echo_byte;
        final_nat      = !ovf_pend;
      end
      S_CR: begin
        res.byte_value = CH_CR;
      end
      S_LF: begin
        res.byte_value = CH_LF;
      end
      S_LINE: begin
        res.kind       = KIND_LINE;
        res.byte_value = rd_data;
      end
      S_DONE: begin
        res.kind        = KIND_DONE;
        res.line_length = end_cnt;
        final_nat       = 1'b1;
      end
      S_RECALL: begin
        res.byte_value = rd_data;
        final_nat      = at_end;
      end
      S_WARN: begin
        res.byte_value = warn_char(idx[4:0]);
      end
      S_OVER: begin
        res.kind  = KIND_OVER;
        final_nat = 1'b1;
      end
      default: begin
        res.kind = KIND_ECHO;
      end
    endcase
    // the result count per byte is capped
    res.last = final_nat || (cnt == CNT_LAST);
  end

  assign push = (state != S_IDLE) && space;

  // byte decode and sequencing
  always_comb begin
    state_next         = state;
    escape_phase_next  = escape_phase;
    escape_first_next  = escape_first;
    position_next      = position;
    recall_length_next = recall_length;
    idx_next           = idx;
    end_cnt_next       = end_cnt;
    echo_byte_next     = echo_byte;
    ovf_pend_next      = ovf_pend;
    cnt_next           = cnt;
    mem.we             = 1'b0;
    mem.waddr          = position;
    mem.wdata          = rx_byte;

    if (accept) begin
      idx_next = '0;
      cnt_next = '0;
      case (escape_phase)
        ESC_FIRST: begin
          escape_first_next = rx_byte;
          escape_phase_next = ESC_SECOND;
        end
        ESC_SECOND: begin
          escape_phase_next = ESC_NONE;
          if (position == '0 && escape_first == CH_LBRACKET && rx_byte == CH_UPPER_A) begin
            if (recall_length >= lim_m1) begin
              state_next = S_WARN;
            end else if (recall_length != '0) begin
              state_next    = S_RECALL;
              end_cnt_next  = recall_length;
              position_next = recall_length;
            end
          end
        end
        default: begin
          if (rx_byte == CH_ESC) begin
            escape_phase_next = ESC_FIRST;
          end else if (rx_byte inside {CH_CR, CH_LF}) begin
            state_next         = S_CR;
            end_cnt_next       = position;
            recall_length_next = position;
            position_next      = '0;
          end else if (rx_byte == CH_DEL) begin
            if (position != '0) begin
              position_next  = position - LEN_W'(1);
              echo_byte_next = CH_DEL;
              ovf_pend_next  = 1'b0;
              state_next     = S_ECHO;
            end
          end else begin
            mem.we         = 1'b1;
            echo_byte_next = rx_byte;
            state_next     = S_ECHO;
            if (pos_inc >= lim_m1) begin
              ovf_pend_next = 1'b1;
              position_next = '0;
            end else begin
              ovf_pend_next = 1'b0;
              position_next = pos_inc;
            end
          end
        end
      endcase
    end

    if (push) begin
      cnt_next = cnt + CNT_W'(1);
      if (res.last) begin
        state_next = S_IDLE;
        idx_next   = '0;
      end else begin
        case (state)
          S_ECHO: begin
            state_next = S_WARN;
            idx_next   = '0;
          end
          S_CR: begin
            state_next = S_LF;
          end
          S_LF: begin
            state_next = (end_cnt == '0) ? S_DONE : S_LINE;
            idx_next   = '0;
          end
          S_LINE: begin
            if (at_end) begin
              state_next = S_DONE;
            end else begin
              idx_next = idx_inc;
            end
          end
          S_RECALL: begin
            idx_next = idx_inc;
          end
          S_WARN: begin
            if (idx == WARN_END) begin
              state_next = S_OVER;
            end else begin
              idx_next = idx_inc;
            end
          end
          default: begin
            state_next = S_IDLE;
            idx_next   = '0;
          end
        endcase
      end
    end

    // store is read ahead at the index of the next cycle
    mem.raddr = idx_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      escape_phase  <= ESC_NONE;
      escape_first  <= '0;
      position      <= '0;
      recall_length <= '0;
      idx           <= '0;
      end_cnt       <= '0;
      ovf_pend      <= 1'b0;
      cnt           <= '0;
    end else begin
      state         <= state_next;
      escape_phase  <= escape_phase_next;
      escape_first  <= escape_first_next;
      position      <= position_next;
      recall_length <= recall_length_next;
      idx           <= idx_next;
      end_cnt       <= end_cnt_next;
      ovf_pend      <= ovf_pend_next;
      cnt           <= cnt_next;
    end
  end

  // echoed byte
  always_ff @(posedge clk) begin
    echo_byte <= echo_byte_next;
  end

  // last request of a byte returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    push && res.last |=> state == S_IDLE)
    else $error("sequencer busy after last request");

  // without a push a busy sequencer holds its place
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) && !push |=> state == $past(state) && idx == $past(idx))
    else $error("sequencer moved without a push");

  // store index stays inside the line being read
  a_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_LINE || state == S_RECALL) |-> idx < end_cnt)
    else $error("store index past line end");

  // the capped request closes the byte
  a_cap: assert property (@(posedge clk) disable iff (rst)
    push && cnt == CNT_LAST |-> res.last)
    else $error("result cap not marked last");

endmodule

@@ src/serial_line_editor.sv @@
// ----------------------------------------------------------------------------
// serial_line_editor
// Line editor for a serial terminal: echo, delete, escape swallowing, recall
// of the last line, commit of the line to a consumer and overflow warning.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake              payload
//   cfg       in          cfg_valid / cfg_ready  line_limit
//   in        in          in_valid / in_stall    rx_byte
//   out       out         out_valid / out_stall  kind, byte_value, line_length, last
//
// A byte is taken while in_stall is low; the sequencer then yields one result
// request per cycle while the output register has room: 0 or 1 for escape bytes
// and DEL, 1 or 19 for a stored byte, up to 64 for a commit (line length plus 3)
// and up to 61 for a recall. in_stall stays high until the last request of a
// byte has entered the output register; out_stall only holds the sequencer in place.
// Reset is synchronous; the line store is not cleared.
module serial_line_editor import sle_pkg::*; #(
  parameter int LINE_STORE = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LEN_W-1:0]  line_limit,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        kind,
  output logic [BYTE_W-1:0] byte_value,
  output logic [LEN_W-1:0]  line_length,
  output logic              last
);

  localparam int AW = $clog2(LINE_STORE);

  logic [LEN_W-1:0]  limit;
  logic              space;
  logic              push;
  result_t           res;
  result_t           res_out;
  mem_req_t          mem;
  logic [BYTE_W-1:0] rd_data;

  // line limit register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LEN_W'(63);
    end else if (cfg_valid && cfg_ready) begin
      limit <= line_limit;
    end
  end

  // sequencer
  sle_ctrl #(
    .LINE_STORE (LINE_STORE)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .limit    (limit),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .space    (space),
    .push     (push),
    .res      (res),
    .mem      (mem),
    .rd_data  (rd_data)
  );

  // line store
  sle_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (LINE_STORE)
  ) u_store (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr[AW-1:0]),
    .wdata (mem.wdata),
    .raddr (mem.raddr[AW-1:0]),
    .rdata (rd_data)
  );

  // output register
  sle_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .res_in    (res),
    .space     (space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (res_out)
  );

  assign kind        = res_out.kind;
  assign byte_value  = res_out.byte_value;
  assign line_length = res_out.line_length;
  assign last        = res_out.last;

endmodule

@@ tb/serial_line_editor_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_line_editor_tb
// Feeds received bytes to the line editor with random idling on both sides
// and one long consumer hold-off. A behavioral copy of the editor predicts
// every echo, line byte, completion and overflow request, and each result is
// checked field by field, in order, against those predictions.
// ----------------------------------------------------------------------------
module serial_line_editor_tb;
  import sle_pkg::*;

  typedef enum logic [1:0] {ESC_IDLE, ESC_WANT_FIRST, ESC_WANT_SECOND} esc_state_t;

  localparam int STORE_DEPTH = 64;
  localparam logic [LEN_W-1:0] LIMIT_AT_RESET = 6'd63;
  localparam logic [8*WARN_LEN-1:0] WARN_TEXT = "Buffer Exceeded\r\n";
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_ITEMS = 64;
  localparam int PHASES = 8;
  localparam int LONG_HOLD = 300;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [LEN_W-1:0]  line_limit = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] rx_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        kind;
  logic [BYTE_W-1:0] byte_value;
  logic [LEN_W-1:0]  line_length;
  logic              last;

  // predicted editor state
  logic [BYTE_W-1:0] line_mem [STORE_DEPTH];
  logic [LEN_W-1:0]  line_pos = '0;
  logic [LEN_W-1:0]  recall_len = '0;
  esc_state_t        esc_state = ESC_IDLE;
  logic [BYTE_W-1:0] esc_first = '0;
  logic [LEN_W-1:0]  limit_reg = LIMIT_AT_RESET;

  result_t pending_out [$];
  int      errors = 0;
  int      sent_items = 0;
  int      hold_cycles = 0;
  bit      idle_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  serial_line_editor #(
    .LINE_STORE(STORE_DEPTH)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .line_limit (line_limit),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .byte_value (byte_value),
    .line_length(line_length),
    .last       (last)
  );

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic void queue_out(input logic [1:0] k, input logic [BYTE_W-1:0] v,
                                    input logic [LEN_W-1:0] n);
    result_t r;
    r.kind        = k;
    r.byte_value  = v;
    r.line_length = n;
    r.last        = 1'b0;
    pending_out.push_back(r);
  endfunction

  // warning text, overflow request, line dropped
  function automatic void warn_and_drop();
    int k;
    for (k = 0; k < WARN_LEN; k++) begin
      queue_out(KIND_ECHO, WARN_TEXT[8*(WARN_LEN-1-k) +: 8], '0);
    end
    queue_out(KIND_OVER, '0, '0);
    line_pos = '0;
  endfunction

  function automatic void edit_byte(input logic [BYTE_W-1:0] b);
    int      lim;
    int      start_n;
    int      k;
    result_t r;
    lim     = (limit_reg < 2) ? 2 : int'(limit_reg);
    start_n = pending_out.size();
    case (esc_state)
      ESC_WANT_FIRST: begin
        esc_first = b;
        esc_state = ESC_WANT_SECOND;
      end
      ESC_WANT_SECOND: begin
        esc_state = ESC_IDLE;
        // up arrow on an empty line brings back the last committed line
        if (line_pos == 0 && esc_first == CH_LBRACKET && b == CH_UPPER_A) begin
          if (int'(recall_len) >= lim - 1) begin
            warn_and_drop();
          end else begin
            for (k = 0; k < int'(recall_len); k++) begin
              queue_out(KIND_ECHO, line_mem[k], '0);
            end
            line_pos = recall_len;
          end
        end
      end
      default: begin
        if (b == CH_ESC) begin
          esc_state = ESC_WANT_FIRST;
        end else if (b == CH_CR || b == CH_LF) begin
          // commit: crlf echo, line bytes, then completion with length
          queue_out(KIND_ECHO, CH_CR, '0);
          queue_out(KIND_ECHO, CH_LF, '0);
          for (k = 0; k < int'(line_pos); k++) begin
            queue_out(KIND_LINE, line_mem[k], '0);
          end
          queue_out(KIND_DONE, '0, line_pos);
          recall_len = line_pos;
          line_pos   = '0;
        end else if (b == CH_DEL) begin
          if (line_pos != 0) begin
            line_pos = line_pos - 1'b1;
            queue_out(KIND_ECHO, CH_DEL, '0);
          end
        end else begin
          queue_out(KIND_ECHO, b, '0);
          line_mem[line_pos] = b;
          line_pos = line_pos + 1'b1;
          if (int'(line_pos) >= lim - 1) begin
            warn_and_drop();
          end
        end
      end
    endcase
    // flag the final request of this byte
    if (pending_out.size() > start_n) begin
      r = pending_out.pop_back();
      r.last = 1'b1;
      pending_out.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  function automatic void check_out();
    result_t want;
    if (pending_out.size() == 0) begin
      $error("unexpected request: kind %0d byte_value %0d line_length %0d last %0d",
             kind, byte_value, line_length, last);
      errors++;
      return;
    end
    want = pending_out.pop_front();
    if (kind !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, kind);
      errors++;
    end
    if (byte_value !== want.byte_value) begin
      $error("byte_value: expected %0d, got %0d", want.byte_value, byte_value);
      errors++;
    end
    if (line_length !== want.line_length) begin
      $error("line_length: expected %0d, got %0d", want.line_length, line_length);
      errors++;
    end
    if (last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, last);
      errors++;
    end
  endfunction

  // sample every accepted request on the three channels
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) check_out();
      if (cfg_valid && cfg_ready) limit_reg = line_limit;
      if (in_valid && !in_stall) edit_byte(rx_byte);
    end
  end

  // consumer side: random stall bursts plus an optional long hold-off
  initial begin : consumer_stall
    int burst;
    burst = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 17);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one byte request; valid stays up so a following byte can go back to back
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  // drop valid, wait for all predicted requests, then let the sequencer finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LEN_W-1:0] v);
    settle();
    cfg_valid  <= 1'b1;
    line_limit <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] pick_printable();
    logic [BYTE_W-1:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == CH_ESC || b == CH_CR || b == CH_LF || b == CH_DEL);
    return b;
  endfunction

  task automatic send_up_arrow();
    send_byte(CH_ESC);
    send_byte(CH_LBRACKET);
    send_byte(CH_UPPER_A);
  endtask

  // well-formed line: optional recall, edits, then cr or lf
  task automatic send_line();
    int len;
    int pick;
    int k;
    pick = $urandom_range(0, 23);
    if (pick == 0) len = $urandom_range(61, 62);
    else if (pick < 3) len = $urandom_range(7, 62);
    else len = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) send_up_arrow();
    for (k = 0; k < len; k++) begin
      if (len < 20 && $urandom_range(0, 9) == 0) send_byte(CH_DEL);
      else send_byte(pick_printable());
    end
    send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
  endtask

  // raw bytes or a broken escape
  task automatic send_noise();
    int n;
    if ($urandom_range(0, 1)) begin
      send_byte(CH_ESC);
      send_byte(8'($urandom_range(0, 255)));
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // nothing committed yet, so the recall is empty and silent
  task automatic test_recall_empty();
    send_up_arrow();
    settle();
  endtask

  // del on empty line, extreme byte values stored, del, commit
  task automatic test_basic_edit();
    send_byte(CH_DEL);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h78);
    send_byte(CH_DEL);
    send_byte(CH_CR);
    settle();
  endtask

  // escapes on a non-empty line swallow cr, lf, del and esc
  task automatic test_escape_swallow();
    send_byte(8'h71);
    send_byte(CH_ESC);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(CH_ESC);
    send_byte(CH_DEL);
    send_byte(CH_ESC);
    send_byte(CH_LF);
    settle();
  endtask

  // recall the last line and keep editing at its end
  task automatic test_recall();
    send_up_arrow();
    send_byte(8'h7A);
    send_byte(CH_CR);
    settle();
  endtask

  // clamped limits: instant overflow, recall too long, empty commit
  task automatic test_limit_extremes();
    write_limit(6'd0);
    send_byte(8'h61);
    send_up_arrow();
    send_byte(CH_LF);
    write_limit(6'd1);
    send_byte(8'h62);
    write_limit(LIMIT_AT_RESET);
  endtask

  // consumer holds off while full-length lines are typed, recalled, committed
  task automatic test_backpressure();
    int k;
    settle();
    hold_cycles = LONG_HOLD;
    for (k = 0; k < 61; k++) begin
      send_byte(pick_printable());
    end
    send_byte(CH_CR);
    send_up_arrow();
    send_byte(CH_LF);
    settle();
  endtask

  // random lines and noise over several limit settings; last phase runs flat out
  task automatic test_random_lines();
    int               p;
    int               phase_goal;
    logic [LEN_W-1:0] lim;
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       lim = 6'd63;
        1:       lim = 6'd1;
        2:       lim = 6'd5;
        3:       lim = 6'($urandom_range(2, 62));
        4:       lim = 6'd2;
        5:       lim = 6'd40;
        6:       lim = 6'($urandom_range(0, 63));
        default: lim = 6'd63;
      endcase
      if (p == PHASES - 1) idle_on = 1'b0;
      write_limit(lim);
      phase_goal = sent_items + RANDOM_ITEMS / PHASES;
      while (sent_items < phase_goal) begin
        if ($urandom_range(0, 4) == 0) send_noise();
        else send_line();
      end
    end
    settle();
  endtask

  initial begin : main
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_recall_empty();
    test_basic_edit();
    test_escape_swallow();
    test_recall();
    test_limit_extremes();
    test_backpressure();
    test_random_lines();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #(30_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule
